// File: design/fbdrt_pkg.sv
// Shared types and constants for the frame buffer dirty rectangle tracker
`default_nettype none

package fbdrt_pkg;

   // physical coordinate bits, enough for frame sizes up to 1024 in either axis
   localparam int CW = 10;

   // command codes
   localparam logic [1:0] CMD_DRAW   = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_ROTATION = 2'd0;
   localparam logic [1:0] CSR_X_OFFSET = 2'd1;
   localparam logic [1:0] CSR_Y_OFFSET = 2'd2;

   // pixel value the store holds after reset
   localparam logic [15:0] PIXEL_WHITE = 16'hFFFF;

   // request payload
   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] x_coord;
      logic signed [15:0] y_coord;
      logic [15:0]        pixel_color;
      logic               force_full_width;
      logic               force_full_height;
   } req_type;

   // response payload
   typedef struct packed {
      logic [15:0] read_color;
      logic        pixel_changed;
      logic        window_empty;
      logic        full_width;
      logic [7:0]  win_x;
      logic [8:0]  win_y;
      logic [7:0]  win_w;
      logic [8:0]  win_h;
   } rsp_type;

   // request after offset, bounds check and rotation
   typedef struct packed {
      logic          valid;
      logic [1:0]    command;
      logic          in_bounds;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
      logic [15:0]   pixel_color;
      logic          force_full_width;
      logic          force_full_height;
   } loc_type;

   // operation handed to the dirty bounds tracker
   typedef struct packed {
      logic          draw_hit;
      logic          update;
      logic          force_full_width;
      logic          force_full_height;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
   } dirty_op_type;

   // window reported by an update
   typedef struct packed {
      logic       window_empty;
      logic       full_width;
      logic [7:0] win_x;
      logic [8:0] win_y;
      logic [7:0] win_w;
      logic [8:0] win_h;
   } window_type;

endpackage

`default_nettype wire

// File: design/fbdrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
`default_nettype none

module fbdrt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 76800
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old value on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/fbdrt_locate.sv
// Two-stage logical-to-physical coordinate mapper with bounds check
`default_nettype none

module fbdrt_locate
   import fbdrt_pkg::*;
#(
   parameter int FB_WIDTH  = 240,
   parameter int FB_HEIGHT = 320
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire req_type            in_req,
   input  wire logic [1:0]         rotation,
   input  wire logic signed [15:0] x_offset,
   input  wire logic signed [15:0] y_offset,
   output      loc_type            loc
);

   localparam logic signed [16:0] W_S  = 17'(FB_WIDTH);
   localparam logic signed [16:0] H_S  = 17'(FB_HEIGHT);
   localparam logic signed [16:0] W_M1 = 17'(FB_WIDTH - 1);
   localparam logic signed [16:0] H_M1 = 17'(FB_HEIGHT - 1);

   typedef struct packed {
      logic               valid;
      logic [1:0]         command;
      logic signed [16:0] lx;
      logic signed [16:0] ly;
      logic [15:0]        pixel_color;
      logic               force_full_width;
      logic               force_full_height;
   } stage_a_type;

   stage_a_type a_ff, a_in;
   loc_type     loc_ff, loc_in;

   logic signed [16:0] lx, ly, lw, lh, px_w, py_w;
   logic               inb;

   // offset add, one bit wider so it never wraps
   always_comb begin
      a_in.valid             = in_valid;
      a_in.command           = in_req.command;
      a_in.lx                = {in_req.x_coord[15], in_req.x_coord} + {x_offset[15], x_offset};
      a_in.ly                = {in_req.y_coord[15], in_req.y_coord} + {y_offset[15], y_offset};
      a_in.pixel_color       = in_req.pixel_color;
      a_in.force_full_width  = in_req.force_full_width;
      a_in.force_full_height = in_req.force_full_height;
   end

   assign lx = a_ff.lx;
   assign ly = a_ff.ly;
   assign lw = rotation[0] ? H_S : W_S;
   assign lh = rotation[0] ? W_S : H_S;
   assign inb = (lx >= 17'sd0) && (lx < lw) && (ly >= 17'sd0) && (ly < lh);

   // quarter-turn mapping to physical coordinates
   always_comb begin
      case (rotation)
         2'd1: begin
            px_w = W_M1 - ly;
            py_w = lx;
         end
         2'd2: begin
            px_w = W_M1 - lx;
            py_w = H_M1 - ly;
         end
         2'd3: begin
            px_w = ly;
            py_w = H_M1 - lx;
         end
         default: begin
            px_w = lx;
            py_w = ly;
         end
      endcase
   end

   always_comb begin
      loc_in.valid             = a_ff.valid;
      loc_in.command           = a_ff.command;
      loc_in.in_bounds         = inb;
      loc_in.px                = inb ? px_w[CW-1:0] : '0;
      loc_in.py                = inb ? py_w[CW-1:0] : '0;
      loc_in.pixel_color       = a_ff.pixel_color;
      loc_in.force_full_width  = a_ff.force_full_width;
      loc_in.force_full_height = a_ff.force_full_height;
   end

   // stage registers, advance together with the rest of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid   <= 1'b0;
         loc_ff.valid <= 1'b0;
      end else if (enable) begin
         a_ff   <= a_in;
         loc_ff <= loc_in;
      end
   end

   assign loc = loc_ff;

endmodule

`default_nettype wire

// File: design/fbdrt_dirty.sv
// Dirty rectangle bounds and update window generation
`default_nettype none

module fbdrt_dirty
   import fbdrt_pkg::*;
#(
   parameter int FB_WIDTH  = 240,
   parameter int FB_HEIGHT = 320
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         enable,
   input  wire dirty_op_type op,
   output      window_type   win
);

   localparam int XB = $clog2(FB_WIDTH + 1);
   localparam int YB = $clog2(FB_HEIGHT + 1);
   localparam logic [XB-1:0] W_X = XB'(FB_WIDTH);
   localparam logic [YB-1:0] H_Y = YB'(FB_HEIGHT);

   // right and bottom are kept as one past the last dirty column / row
   logic [XB-1:0] left_ff, left_in, right1_ff, right1_in;
   logic [YB-1:0] top_ff, top_in, bot1_ff, bot1_in;

   logic [XB-1:0] px, px1, fl, fr1, w;
   logic [YB-1:0] py, py1, ft, fb1, h;
   logic          empty;

   assign px  = XB'(op.px);
   assign py  = YB'(op.py);
   assign px1 = px + XB'(1);
   assign py1 = py + YB'(1);

   // forced ranges apply before the emptiness test
   assign fl    = op.force_full_width  ? '0  : left_ff;
   assign fr1   = op.force_full_width  ? W_X : right1_ff;
   assign ft    = op.force_full_height ? '0  : top_ff;
   assign fb1   = op.force_full_height ? H_Y : bot1_ff;
   assign empty = (fr1 <= fl) || (fb1 <= ft);
   assign w     = fr1 - fl;
   assign h     = fb1 - ft;

   // window report, zero fields when empty
   always_comb begin
      win = '0;
      if (empty) begin
         win.window_empty = 1'b1;
      end else begin
         win.full_width = (w == W_X);
         win.win_x      = 8'(fl);
         win.win_y      = 9'(ft);
         win.win_w      = 8'(w);
         win.win_h      = 9'(h);
      end
   end

   // bounds update on a changing draw or an update
   always_comb begin
      left_in   = left_ff;
      right1_in = right1_ff;
      top_in    = top_ff;
      bot1_in   = bot1_ff;
      if (enable && op.draw_hit) begin
         if (px < left_ff)    left_in   = px;
         if (px1 > right1_ff) right1_in = px1;
         if (py < top_ff)     top_in    = py;
         if (py1 > bot1_ff)   bot1_in   = py1;
      end else if (enable && op.update) begin
         if (empty) begin
            left_in   = fl;
            right1_in = fr1;
            top_in    = ft;
            bot1_in   = fb1;
         end else begin
            left_in   = W_X;
            right1_in = '0;
            top_in    = H_Y;
            bot1_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= W_X;
         right1_ff <= '0;
         top_ff    <= H_Y;
         bot1_ff   <= '0;
      end else begin
         left_ff   <= left_in;
         right1_ff <= right1_in;
         top_ff    <= top_in;
         bot1_ff   <= bot1_in;
      end
   end

endmodule

`default_nettype wire

// File: design/framebuffer_dirty_rect_tracker.sv
// Frame store with dirty rectangle tracking: request pipeline, store and control
// Path: two locate stage registers, then the compare stage and response registers.
// Throughput: one request per cycle when not stalled; set by the single read-compare-write
// path on the frame store RAM, with the last draw write forwarded to the compare stage.
// Reset: synchronous; rotation and offsets clear to 0 and the dirty bounds to empty.
// After reset a sweep fills all FB_WIDTH*FB_HEIGHT pixels (76800 by default) of the store
// with white, one pixel a cycle, while req_stall stays high.
`default_nettype none

module framebuffer_dirty_rect_tracker
   import fbdrt_pkg::*;
#(
   parameter int FB_WIDTH  = 240,
   parameter int FB_HEIGHT = 320
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int DEPTH  = FB_WIDTH * FB_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] W_A      = ADDR_W'(FB_WIDTH);
   localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(DEPTH - 1);

   logic [1:0]         rotation_ff, rotation_in;
   logic signed [15:0] x_offset_ff, x_offset_in, y_offset_ff, y_offset_in;

   logic              clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   loc_type           loc, c_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   logic              fwd_we_ff, fwd_we_in;
   logic [ADDR_W-1:0] fwd_addr_ff, fwd_addr_in;
   logic [15:0]       fwd_data_ff, fwd_data_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              adv, req_accept, hit, changed, draw_we;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [15:0]       ram_wdata, ram_q, stored;
   dirty_op_type      dop;
   window_type        win;

   // configuration registers
   always_comb begin
      rotation_in = rotation_ff;
      x_offset_in = x_offset_ff;
      y_offset_in = y_offset_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROTATION: rotation_in = csr_wdata[1:0];
            CSR_X_OFFSET: x_offset_in = csr_wdata;
            CSR_Y_OFFSET: y_offset_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advances whenever the response register can take a new value
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = clr_active_ff || !adv;
   assign req_accept = req_valid && !req_stall;

   fbdrt_locate #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_locate (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (req_accept),
      .in_req   (req_data),
      .rotation (rotation_ff),
      .x_offset (x_offset_ff),
      .y_offset (y_offset_ff),
      .loc      (loc)
   );

   // row-major store address, read issued as the request enters the compare stage
   assign addr_in = ADDR_W'(loc.py) * W_A + ADDR_W'(loc.px);

   // compare stage: forward the draw write made when the pipeline last advanced
   assign stored  = (fwd_we_ff && (fwd_addr_ff == addr_ff)) ? fwd_data_ff : ram_q;
   assign hit     = c_ff.valid && c_ff.in_bounds;
   assign changed = hit && (c_ff.command == CMD_DRAW) && (stored != c_ff.pixel_color);
   assign draw_we = adv && changed;

   assign fwd_we_in   = changed;
   assign fwd_addr_in = addr_ff;
   assign fwd_data_in = c_ff.pixel_color;

   // store write port shared by the fill sweep and pixel draws
   assign ram_we    = clr_active_ff || draw_we;
   assign ram_waddr = clr_active_ff ? clr_addr_ff : addr_ff;
   assign ram_wdata = clr_active_ff ? PIXEL_WHITE : c_ff.pixel_color;

   fbdrt_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (adv),
      .raddr (addr_in),
      .rdata (ram_q)
   );

   // dirty bounds
   always_comb begin
      dop.draw_hit          = changed;
      dop.update            = c_ff.valid && (c_ff.command == CMD_UPDATE);
      dop.force_full_width  = c_ff.force_full_width;
      dop.force_full_height = c_ff.force_full_height;
      dop.px                = c_ff.px;
      dop.py                = c_ff.py;
   end

   fbdrt_dirty #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_dirty (
      .clock  (clock),
      .reset  (reset),
      .enable (adv),
      .op     (dop),
      .win    (win)
   );

   // response assembly
   always_comb begin
      rsp_valid_in  = c_ff.valid;
      rsp_data_in   = '0;
      if (hit && (c_ff.command == CMD_READ)) begin
         rsp_data_in.read_color = stored;
      end
      rsp_data_in.pixel_changed = changed;
      if (dop.update) begin
         rsp_data_in.window_empty = win.window_empty;
         rsp_data_in.full_width   = win.full_width;
         rsp_data_in.win_x        = win.win_x;
         rsp_data_in.win_y        = win.win_y;
         rsp_data_in.win_w        = win.win_w;
         rsp_data_in.win_h        = win.win_h;
      end
   end

   // fill sweep after reset
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in   = clr_addr_ff + ADDR_W'(1);
         clr_active_in = (clr_addr_ff != LAST_A);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff   <= '0;
         x_offset_ff   <= '0;
         y_offset_ff   <= '0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         c_ff.valid    <= 1'b0;
         fwd_we_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rotation_ff   <= rotation_in;
         x_offset_ff   <= x_offset_in;
         y_offset_ff   <= y_offset_in;
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         if (adv) begin
            c_ff         <= loc;
            addr_ff      <= addr_in;
            fwd_we_ff    <= fwd_we_in;
            fwd_addr_ff  <= fwd_addr_in;
            fwd_data_ff  <= fwd_data_in;
            rsp_valid_ff <= rsp_valid_in;
            rsp_data_ff  <= rsp_data_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // no request enters while the store is being filled
   a_stall_in_fill: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> req_stall)
      else $error("request port open during fill sweep");

   // the pipeline is empty during the fill sweep, so draws never collide with it
   a_no_draw_in_fill: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !c_ff.valid)
      else $error("compare stage busy during fill sweep");

   // a new response only comes from an item in the compare stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(c_ff.valid))
      else $error("response appeared without a request behind it");

   // a full-width window starts at the left edge
   a_full_width_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.full_width) |-> (rsp_data_ff.win_x == 8'd0))
      else $error("full-width window does not start at column zero");
`endif

endmodule

`default_nettype wire

// File: bench/framebuffer_dirty_rect_tracker_tb.sv
// Self-checking bench for the frame buffer dirty rectangle tracker
`timescale 1ns / 1ps

module framebuffer_dirty_rect_tracker_tb
   import fbdrt_pkg::*;
();

   localparam int FB_W   = 240;
   localparam int FB_H   = 320;
   localparam int PIXELS = FB_W * FB_H;

   // command value the block ignores
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   // shadow copy of the frame, dirty bounds and registers
   logic [15:0] shadow_pixels [PIXELS];
   int          shadow_left, shadow_right, shadow_top, shadow_bottom;
   logic [1:0]  shadow_rotation;
   int          shadow_x_off, shadow_y_off;

   // responses predicted for accepted requests, oldest first
   rsp_type     pending_results [$];

   int fail_count    = 0;
   int checked_count = 0;
   int draw_count    = 0;
   int read_count    = 0;
   int update_count  = 0;
   int unused_count  = 0;
   int changed_count = 0;
   int window_count  = 0;

   bit req_gaps_on     = 1'b1;
   bit rsp_gaps_on     = 1'b1;
   int rsp_hold_cycles = 0;
   int stall_left;
   int focus_x, focus_y;

   framebuffer_dirty_rect_tracker #(
      .FB_WIDTH  (FB_W),
      .FB_HEIGHT (FB_H)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit: clearing sweep plus slowest traffic, with wide margin
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void clear_dirty_bounds();
      shadow_left   = FB_W;
      shadow_right  = -1;
      shadow_top    = FB_H;
      shadow_bottom = -1;
   endfunction

   function automatic int logical_width();
      return shadow_rotation[0] ? FB_H : FB_W;
   endfunction

   function automatic int logical_height();
      return shadow_rotation[0] ? FB_W : FB_H;
   endfunction

   // offset, bounds check and rotation into a frame index
   function automatic bit map_point(input logic signed [15:0] xc,
                                    input logic signed [15:0] yc, output int idx);
      int lx, ly, px, py;
      lx  = int'(xc) + shadow_x_off;
      ly  = int'(yc) + shadow_y_off;
      idx = 0;
      if (lx < 0 || ly < 0 || lx >= logical_width() || ly >= logical_height())
         return 1'b0;
      case (shadow_rotation)
         2'd1: begin
            px = FB_W - 1 - ly;
            py = lx;
         end
         2'd2: begin
            px = FB_W - 1 - lx;
            py = FB_H - 1 - ly;
         end
         2'd3: begin
            px = ly;
            py = FB_H - 1 - lx;
         end
         default: begin
            px = lx;
            py = ly;
         end
      endcase
      idx = py * FB_W + px;
      return 1'b1;
   endfunction

   // apply one request to the shadow frame and work out its response
   function automatic void shadow_frame_step(input req_type r, output rsp_type res);
      int idx, px, py, w, h;
      res = '0;
      case (r.command)
         CMD_DRAW: begin
            if (map_point(r.x_coord, r.y_coord, idx) && shadow_pixels[idx] != r.pixel_color) begin
               px = idx % FB_W;
               py = idx / FB_W;
               shadow_pixels[idx] = r.pixel_color;
               res.pixel_changed = 1'b1;
               if (px < shadow_left)   shadow_left   = px;
               if (px > shadow_right)  shadow_right  = px;
               if (py < shadow_top)    shadow_top    = py;
               if (py > shadow_bottom) shadow_bottom = py;
            end
         end
         CMD_READ: begin
            if (map_point(r.x_coord, r.y_coord, idx))
               res.read_color = shadow_pixels[idx];
         end
         CMD_UPDATE: begin
            if (r.force_full_width) begin
               shadow_left  = 0;
               shadow_right = FB_W - 1;
            end
            if (r.force_full_height) begin
               shadow_top    = 0;
               shadow_bottom = FB_H - 1;
            end
            // empty window keeps the bounds, forced ranges included
            if (shadow_right < shadow_left || shadow_bottom < shadow_top) begin
               res.window_empty = 1'b1;
            end else begin
               w = shadow_right - shadow_left + 1;
               h = shadow_bottom - shadow_top + 1;
               res.full_width = (w == FB_W);
               res.win_x      = 8'(shadow_left);
               res.win_y      = 9'(shadow_top);
               res.win_w      = 8'(w);
               res.win_h      = 9'(h);
               clear_dirty_bounds();
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // draw or read at a logical point, offsets already taken out
   function automatic req_type point_request(input logic [1:0] cmd, input int lx,
                                             input int ly, input logic [15:0] color);
      req_type r;
      r             = '0;
      r.command     = cmd;
      r.x_coord     = 16'(lx - shadow_x_off);
      r.y_coord     = 16'(ly - shadow_y_off);
      r.pixel_color = color;
      return r;
   endfunction

   function automatic req_type update_request(input bit fw, input bit fh);
      req_type r;
      r                   = '0;
      r.command           = CMD_UPDATE;
      r.force_full_width  = fw;
      r.force_full_height = fh;
      return r;
   endfunction

   function automatic void move_focus();
      focus_x = $urandom_range(0, logical_width() - 1);
      focus_y = $urandom_range(0, logical_height() - 1);
   endfunction

   // mostly draws and reads clustered around a focus point, some updates and noise
   function automatic req_type random_request();
      req_type r;
      int      pick, tx, ty;
      pick                = $urandom_range(0, 99);
      r.command           = 2'($urandom_range(0, 3));
      r.x_coord           = 16'($urandom_range(0, 65535));
      r.y_coord           = 16'($urandom_range(0, 65535));
      r.pixel_color       = 16'($urandom_range(0, 65535));
      r.force_full_width  = 1'($urandom_range(0, 1));
      r.force_full_height = 1'($urandom_range(0, 1));
      if (pick < 4) begin
         r.command = CMD_UNUSED;
         return r;
      end
      if (pick < 9)
         return r;
      if (pick < 21) begin
         r.command           = CMD_UPDATE;
         r.force_full_width  = ($urandom_range(0, 7) == 0);
         r.force_full_height = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 1))
            move_focus();
         return r;
      end
      r.command = (pick < 70) ? CMD_DRAW : CMD_READ;
      if ($urandom_range(0, 9) < 7) begin
         tx = focus_x + int'($urandom_range(0, 8)) - 4;
         ty = focus_y + int'($urandom_range(0, 8)) - 4;
      end else begin
         tx = int'($urandom_range(0, logical_width() + 3)) - 2;
         ty = int'($urandom_range(0, logical_height() + 3)) - 2;
      end
      r.x_coord = 16'(tx - shadow_x_off);
      r.y_coord = 16'(ty - shadow_y_off);
      // a small palette makes repeated draws of the same color likely
      if (r.command == CMD_DRAW && $urandom_range(0, 1)) begin
         case ($urandom_range(0, 3))
            0:       r.pixel_color = 16'h0000;
            1:       r.pixel_color = PIXEL_WHITE;
            2:       r.pixel_color = 16'h5555;
            default: r.pixel_color = 16'hAAAA;
         endcase
      end
      return r;
   endfunction

   // offer one request, predict its response once accepted
   task automatic send_request(input req_type r);
      int      gap;
      rsp_type res;
      gap = req_gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      shadow_frame_step(r, res);
      pending_results.push_back(res);
      case (r.command)
         CMD_DRAW:   draw_count++;
         CMD_READ:   read_count++;
         CMD_UPDATE: update_count++;
         default:    unused_count++;
      endcase
      changed_count += int'(res.pixel_changed);
      if (r.command == CMD_UPDATE && !res.window_empty)
         window_count++;
   endtask

   // stop offering and wait for every predicted response
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ROTATION: shadow_rotation = value[1:0];
         CSR_X_OFFSET: shadow_x_off    = int'($signed(value));
         CSR_Y_OFFSET: shadow_y_off    = int'($signed(value));
         default: ;
      endcase
   endtask

   task automatic set_mode(input logic [1:0] rot, input int xo, input int yo);
      wait_idle();
      write_csr(CSR_ROTATION, 16'(rot));
      write_csr(CSR_X_OFFSET, 16'(xo));
      write_csr(CSR_Y_OFFSET, 16'(yo));
      move_focus();
   endtask

   // field extremes, repeat draws, out of range points and all update cases
   task automatic test_directed_ops();
      req_type r;
      set_mode(2'd0, 0, 0);
      send_request(point_request(CMD_READ, 0, 0, 16'h0));
      send_request(point_request(CMD_DRAW, 0, 0, 16'h0000));
      send_request(point_request(CMD_DRAW, 0, 0, 16'h0000));
      send_request(point_request(CMD_DRAW, FB_W - 1, FB_H - 1, 16'h8001));
      send_request(point_request(CMD_READ, FB_W - 1, FB_H - 1, 16'h0));
      send_request(point_request(CMD_DRAW, FB_W, 5, 16'h1111));
      send_request(point_request(CMD_DRAW, -1, 5, 16'h2222));
      send_request(point_request(CMD_READ, 0, FB_H, 16'h0));
      send_request(point_request(CMD_READ, 32767, -32768, 16'hFFFF));
      send_request(point_request(CMD_DRAW, 5, 5, PIXEL_WHITE));
      send_request(update_request(1'b0, 1'b0));
      send_request(update_request(1'b0, 1'b0));
      // forced ranges on an empty rectangle stay for the next update
      send_request(update_request(1'b1, 1'b0));
      send_request(point_request(CMD_DRAW, 10, 20, 16'h1234));
      send_request(update_request(1'b0, 1'b0));
      send_request(update_request(1'b0, 1'b1));
      send_request(update_request(1'b1, 1'b1));
      r = '1;
      send_request(r);
   endtask

   // opposite logical corners under each quarter turn
   task automatic test_rotation_corners();
      for (int rot = 1; rot < 4; rot++) begin
         set_mode(2'(rot), 5 * rot, -3 * rot);
         send_request(point_request(CMD_DRAW, 0, 0, 16'(16'h0100 * rot)));
         send_request(point_request(CMD_DRAW, logical_width() - 1, logical_height() - 1,
                                    16'(16'h0200 * rot)));
         send_request(update_request(1'b0, 1'b0));
      end
   endtask

   // receiver holds off long enough that the block fills and stalls requests
   task automatic test_output_backpressure();
      set_mode(2'd0, 0, 0);
      req_gaps_on     = 1'b0;
      rsp_hold_cycles = 80;
      repeat (40) send_request(random_request());
      req_gaps_on = 1'b1;
   endtask

   task automatic run_phase(input logic [1:0] rot, input int xo, input int yo,
                            input int count, input bit gaps);
      set_mode(rot, xo, yo);
      req_gaps_on = gaps;
      rsp_gaps_on = gaps;
      repeat (count) send_request(random_request());
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // random traffic over every rotation and the offset extremes
   task automatic test_random_traffic();
      run_phase(2'd0, 0, 0, 250, 1'b1);
      run_phase(2'd1, 32767, -150, 160, 1'b1);
      run_phase(2'd2, -7, 32767, 160, 1'b0);
      run_phase(2'd3, -32768, -32768, 40, 1'b1);
      run_phase(2'd3, 60, -40, 160, 1'b1);
      run_phase(2'd0, -3, 2, 60, 1'b1);
   endtask

   // response stall: random wait after each response, plus long holds on demand
   initial begin : rsp_throttle
      rsp_stall <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            stall_left = rsp_gaps_on ? $urandom_range(0, 4) : 0;
         else if (stall_left > 0)
            stall_left--;
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (stall_left > 0);
         end
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin : rsp_checker
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("response with nothing pending: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            check_field("read_color", want.read_color, rsp_data.read_color);
            check_field("pixel_changed", 16'(want.pixel_changed),
                        16'(rsp_data.pixel_changed));
            check_field("window_empty", 16'(want.window_empty),
                        16'(rsp_data.window_empty));
            check_field("full_width", 16'(want.full_width), 16'(rsp_data.full_width));
            check_field("win_x", 16'(want.win_x), 16'(rsp_data.win_x));
            check_field("win_y", 16'(want.win_y), 16'(rsp_data.win_y));
            check_field("win_w", 16'(want.win_w), 16'(rsp_data.win_w));
            check_field("win_h", 16'(want.win_h), 16'(rsp_data.win_h));
         end
      end
   end

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_ROTATION;
      csr_wdata <= '0;
      for (int i = 0; i < PIXELS; i++)
         shadow_pixels[i] = PIXEL_WHITE;
      clear_dirty_bounds();
      shadow_rotation = 2'd0;
      shadow_x_off    = 0;
      shadow_y_off    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_rotation_corners();
      test_output_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (10) @(posedge clock);
      $display("%0d requests: %0d draws (%0d changed a pixel), %0d reads, %0d updates",
               draw_count + read_count + update_count + unused_count, draw_count,
               changed_count, read_count, update_count);
      $display("%0d windows reported, %0d unused commands, %0d responses checked",
               window_count, unused_count, checked_count);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (pending_results.size() != 0)
            $error("%0d responses never arrived", pending_results.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
design/fbdrt_pkg.sv
design/fbdrt_ram.sv
design/fbdrt_locate.sv
design/fbdrt_dirty.sv
design/framebuffer_dirty_rect_tracker.sv
bench/framebuffer_dirty_rect_tracker_tb.sv
